@@ rtl/core/ilcp_pkg.sv @@
// Package for the i2c led command parser: event kinds, parser phases,
// bus reply codes and the result record shared by the parser and the top level.
// No dependencies.
`default_nettype none

package ilcp_pkg;

    typedef enum logic [1:0] {
        MODE_ADDR  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        RESP_NONE = 2'd0,
        RESP_ACK  = 2'd1,
        RESP_NACK = 2'd2,
        RESP_READ = 2'd3
    } resp_t;

    localparam logic [3:0] CMD_SET_LEDS = 4'h5;
    localparam int         LED_COUNT    = 4;

    typedef struct packed {
        resp_t       response;
        logic        led_write;
        logic [1:0]  led_number;
        logic [5:0]  red_level;
        logic [5:0]  green_level;
        logic [5:0]  blue_level;
        logic        read_valid;
        logic [2:0]  sensor_index;
        logic        busy_flag;
        logic        changed_flag;
    } ilcp_result_t;

endpackage

`default_nettype wire

@@ rtl/core/i2c_led_command_parser.sv @@
// Top level of the i2c led command parser: input register, parser, result register.
// Depends on ilcp_pkg and ilcp_parser.
//
//   channel | dir | tdata (lsb first)                                     | tuser
//   s_      | in  | rx_byte[7:0]                                          | mode[1:0]
//   m_      | out | response, led_number, red, green, blue, sensor_index, | led_write,
//           |     | busy_flag, changed_flag (27 bits, zero padded to 32)  | read_valid
//
// one item per cycle sustained while the result side does not stall; an accepted input
// passes through both registers before its result can be accepted
// (input register, then the parser logic into the result register)
// s_tready is low only while the input register holds an item blocked by a stalled result
// aresetn clears the parser state and both valid flags directly; no clearing pass
`default_nettype none

module i2c_led_command_parser #(
    parameter int SENSOR_REGS = 6
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // rx_byte[7:0]
    input  wire  [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // response[1:0], led_number[3:2], red_level[9:4],
                                   // green_level[15:10], blue_level[21:16],
                                   // sensor_index[24:22], busy_flag[25], changed_flag[26]
    output logic [1:0]  m_tuser    // led_write[0], read_valid[1]
);
    import ilcp_pkg::*;

    logic         in_valid_reg, in_valid_next;
    logic [1:0]   in_mode_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg, out_valid_next;
    ilcp_result_t out_res_reg;
    ilcp_result_t res;
    logic         advance;
    logic         s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    ilcp_parser #(
        .SENSOR_REGS(SENSOR_REGS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (advance),
        .mode    (in_mode_reg),
        .rx_byte (in_byte_reg),
        .result  (res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_res_reg.changed_flag,
                       out_res_reg.busy_flag,
                       out_res_reg.sensor_index,
                       out_res_reg.blue_level,
                       out_res_reg.green_level,
                       out_res_reg.red_level,
                       out_res_reg.led_number,
                       out_res_reg.response};
    assign m_tuser  = {out_res_reg.read_valid, out_res_reg.led_write};

endmodule

`default_nettype wire

@@ rtl/core/ilcp_parser.sv @@
// Bus event parser: phase machine, led list, colour byte hold, read pointer and flags.
// Evaluates one event per enabled cycle and presents its result combinationally.
// Depends on ilcp_pkg.
`default_nettype none

module ilcp_parser #(
    parameter int SENSOR_REGS = 6
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   en,
    input  wire  [1:0]            mode,
    input  wire  [7:0]            rx_byte,
    output ilcp_pkg::ilcp_result_t result
);
    import ilcp_pkg::*;

    localparam int PTR_W = (SENSOR_REGS > 1) ? $clog2(SENSOR_REGS) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SENSOR_REGS - 1);

    phase_t           phase_reg, phase_next;
    logic [1:0]       list_reg [LED_COUNT];
    logic [1:0]       list_next [LED_COUNT];
    logic [2:0]       count_reg, count_next;
    logic [2:0]       pos_reg, pos_next;
    logic [7:0]       first_reg, first_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             busy_reg, busy_next;
    logic             changed_reg, changed_next;

    mode_t            ev;
    logic             cmd_ok;
    logic [1:0]       cmd_list [LED_COUNT];
    logic [2:0]       cmd_count;
    logic [2:0]       pos_inc;
    logic             list_done;

    assign ev        = mode_t'(mode);
    assign cmd_ok    = (rx_byte[7:4] == CMD_SET_LEDS) && (rx_byte[3:0] != 4'd0);
    assign pos_inc   = pos_reg + 3'd1;
    assign list_done = (pos_inc >= count_reg);

    // compact the mask into a list of led numbers, lowest bit first
    always_comb begin
        cmd_count = 3'd0;
        for (int i = 0; i < LED_COUNT; i++) begin
            cmd_list[i] = list_reg[i];
        end
        for (int i = 0; i < LED_COUNT; i++) begin
            if (rx_byte[i]) begin
                cmd_list[cmd_count[1:0]] = 2'(i);
                cmd_count = cmd_count + 3'd1;
            end
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (en) begin
            unique case (ev)
                MODE_ADDR, MODE_READ: phase_next = PH_IDLE;
                MODE_STOP:            phase_next = phase_reg;
                MODE_WRITE: begin
                    unique case (phase_reg)
                        PH_FIRST:  phase_next = PH_SECOND;
                        PH_SECOND: phase_next = list_done ? PH_IDLE : PH_FIRST;
                        // unused phase code behaves as idle
                        default:   phase_next = cmd_ok ? PH_FIRST : PH_IDLE;
                    endcase
                end
                default: phase_next = phase_reg;
            endcase
        end
    end

    // datapath registers and result
    always_comb begin
        for (int i = 0; i < LED_COUNT; i++) begin
            list_next[i] = list_reg[i];
        end
        count_next   = count_reg;
        pos_next     = pos_reg;
        first_next   = first_reg;
        ptr_next     = ptr_reg;
        busy_next    = busy_reg;
        changed_next = changed_reg;
        result       = '0;
        result.response = RESP_NONE;

        unique case (ev)
            MODE_ADDR: begin
                result.response = RESP_ACK;
                ptr_next   = '0;
                busy_next  = 1'b1;
                count_next = 3'd0;
                pos_next   = 3'd0;
            end
            MODE_READ: begin
                result.response     = RESP_READ;
                result.read_valid   = 1'b1;
                result.sensor_index = 3'(ptr_reg);
                ptr_next   = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + PTR_W'(1);
                count_next = 3'd0;
                pos_next   = 3'd0;
            end
            MODE_STOP: begin
                busy_next = 1'b0;
            end
            MODE_WRITE: begin
                unique case (phase_reg)
                    PH_FIRST: begin
                        first_next      = rx_byte;
                        result.response = RESP_ACK;
                        changed_next    = 1'b1;
                    end
                    PH_SECOND: begin
                        result.response    = RESP_ACK;
                        changed_next       = 1'b1;
                        result.led_write   = 1'b1;
                        result.led_number  = list_reg[pos_reg[1:0]];
                        result.red_level   = first_reg[7:2];
                        result.green_level = {first_reg[1:0], rx_byte[7:4]};
                        result.blue_level  = {rx_byte[3:0], 2'b00};
                        if (list_done) begin
                            count_next = 3'd0;
                            pos_next   = 3'd0;
                        end else begin
                            pos_next = pos_inc;
                        end
                    end
                    default: begin
                        if (cmd_ok) begin
                            for (int i = 0; i < LED_COUNT; i++) begin
                                list_next[i] = cmd_list[i];
                            end
                            count_next      = cmd_count;
                            pos_next        = 3'd0;
                            result.response = RESP_ACK;
                            changed_next    = 1'b1;
                        end else begin
                            count_next      = 3'd0;
                            pos_next        = 3'd0;
                            result.response = RESP_NACK;
                        end
                    end
                endcase
            end
            default: begin
                busy_next = busy_reg;
            end
        endcase

        result.busy_flag    = busy_next;
        result.changed_flag = changed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            count_reg   <= 3'd0;
            pos_reg     <= 3'd0;
            first_reg   <= 8'd0;
            ptr_reg     <= '0;
            busy_reg    <= 1'b0;
            changed_reg <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++) begin
                list_reg[i] <= 2'd0;
            end
        end else if (en) begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            first_reg   <= first_next;
            ptr_reg     <= ptr_next;
            busy_reg    <= busy_next;
            changed_reg <= changed_next;
            for (int i = 0; i < LED_COUNT; i++) begin
                list_reg[i] <= list_next[i];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ilcp_checker.sv @@
// Port-level checks for the i2c led command parser, bound to the top level.
// Sees the top level's ports only; depends on nothing else.
`default_nettype none

module ilcp_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [31:0] m_tdata,
    input wire [1:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // nothing is presented right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an led update is always acknowledged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[1:0] == 2'd1 && !m_tuser[1])
        else $error("led update without ack");

    // a read item answers without ack
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[1:0] == 2'd3)
        else $error("read item with wrong reply");

    // colour and index fields are zero when not flagged
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata[24:2] == 23'd0)
        else $error("stray payload in plain item");

endmodule

bind i2c_led_command_parser ilcp_checker u_ilcp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

@@ verif/tb_i2c_led_command_parser.sv @@
// Testbench for i2c_led_command_parser: bus events are streamed in, and every reply item
// is checked field by field against a cycle-free predictor of the parser.
// Depends on ilcp_pkg and the RTL of i2c_led_command_parser.
`timescale 1ns / 100ps

module tb_i2c_led_command_parser;

    import ilcp_pkg::*;

    localparam int SENSOR_REGS = 6;
    localparam int ITEM_TARGET = 1250;
    localparam int CALM_TAIL   = 150;
    localparam int STALL_LIMIT = 2000;

    // predicts the reply of the parser for every accepted bus event
    class led_bus_replies;
        phase_t       phase;
        logic [1:0]   led_list [4];
        logic [2:0]   list_count;
        logic [2:0]   list_position;
        logic [7:0]   first_byte;
        int           read_ptr;
        bit           busy;
        bit           changed;
        ilcp_result_t awaited_replies [$];
        int           errors;

        function new();
            foreach (led_list[i]) led_list[i] = 2'd0;
            first_byte = 8'd0;
            read_ptr   = 0;
            busy       = 1'b0;
            changed    = 1'b0;
            errors     = 0;
            clear_parser();
        endfunction

        function void clear_parser();
            phase         = PH_IDLE;
            list_position = 3'd0;
            list_count    = 3'd0;
        endfunction

        function void note_event(mode_t mode, logic [7:0] rx);
            ilcp_result_t r;
            bit           ok;
            r  = '0;
            ok = 1'b1;
            case (mode)
                MODE_ADDR: begin
                    r.response = RESP_ACK;
                    read_ptr   = 0;
                    busy       = 1'b1;
                    clear_parser();
                end
                MODE_READ: begin
                    clear_parser();
                    r.response     = RESP_READ;
                    r.read_valid   = 1'b1;
                    r.sensor_index = read_ptr[2:0];
                    read_ptr++;
                    if (read_ptr >= SENSOR_REGS) read_ptr = 0;
                end
                MODE_STOP: begin
                    busy = 1'b0;
                end
                default: begin
                    case (phase)
                        PH_FIRST: begin
                            first_byte = rx;
                            phase      = PH_SECOND;
                        end
                        PH_SECOND: begin
                            r.red_level   = first_byte[7:2];
                            r.green_level = {first_byte[1:0], rx[7:4]};
                            r.blue_level  = {rx[3:0], 2'b00};
                            r.led_number  = led_list[list_position[1:0]];
                            r.led_write   = 1'b1;
                            list_position++;
                            if (list_position >= list_count) clear_parser();
                            else phase = PH_FIRST;
                        end
                        default: begin
                            // command byte; an unknown phase code behaves as idle
                            if (rx[7:4] == CMD_SET_LEDS) begin
                                list_count = 3'd0;
                                for (int i = 0; i < LED_COUNT; i++) begin
                                    if (rx[i]) begin
                                        led_list[list_count[1:0]] = i[1:0];
                                        list_count++;
                                    end
                                end
                                if (list_count != 3'd0) begin
                                    phase         = PH_FIRST;
                                    list_position = 3'd0;
                                end else begin
                                    ok = 1'b0;
                                end
                            end else begin
                                ok = 1'b0;
                            end
                        end
                    endcase
                    if (ok) begin
                        r.response = RESP_ACK;
                        changed    = 1'b1;
                    end else begin
                        clear_parser();
                        r.response = RESP_NACK;
                    end
                end
            endcase
            r.busy_flag    = busy;
            r.changed_flag = changed;
            awaited_replies.push_back(r);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_reply(logic [31:0] data, logic [1:0] user);
            ilcp_result_t want;
            if (awaited_replies.size() == 0) begin
                errors++;
                $display("%0t: reply item with nothing expected, actual tdata %h tuser %b",
                         $time, data, user);
                return;
            end
            want = awaited_replies.pop_front();
            check_field("response",     want.response,     data[1:0]);
            check_field("led_number",   want.led_number,   data[3:2]);
            check_field("red_level",    want.red_level,    data[9:4]);
            check_field("green_level",  want.green_level,  data[15:10]);
            check_field("blue_level",   want.blue_level,   data[21:16]);
            check_field("sensor_index", want.sensor_index, data[24:22]);
            check_field("busy_flag",    want.busy_flag,    data[25]);
            check_field("changed_flag", want.changed_flag, data[26]);
            check_field("led_write",    want.led_write,    user[0]);
            check_field("read_valid",   want.read_valid,   user[1]);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;

    led_bus_replies replies = new();
    int             events_sent = 0;
    int             gap_pct = 0;
    bit             calm = 1'b0;
    int             quiet_cycles = 0;

    i2c_led_command_parser #(
        .SENSOR_REGS(SENSOR_REGS)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // handshake monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) replies.note_event(mode_t'(s_tuser), s_tdata);
            if (m_tvalid && m_tready) replies.check_reply(m_tdata, m_tuser);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("i2c_led_command_parser verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side back-pressure with a randomly redrawn stall rate
    initial begin : rx_stalls
        int stall_pct;
        int cyc;
        stall_pct = 0;
        cyc       = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            cyc++;
            if (cyc % 64 == 0) stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_event(mode_t mode, logic [7:0] rx);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= rx;
        do @(posedge aclk); while (!s_tready);
        events_sent++;
        if (events_sent % 50 == 0) gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        if (events_sent >= ITEM_TARGET - CALM_TAIL) calm = 1'b1;
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies.awaited_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic send_colours(int pairs);
        for (int i = 0; i < 2 * pairs; i++) send_event(MODE_WRITE, 8'($urandom));
    endtask

    initial begin : stimulus
        int          kind;
        logic [3:0]  mask;
        int          pairs;
        mode_t       mode;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tuser  <= MODE_ADDR;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: full list with colour extremes, bad commands, reads past the wrap
        send_event(MODE_ADDR, 8'hFF);
        send_event(MODE_WRITE, 8'h5F);
        send_event(MODE_WRITE, 8'hFF);
        send_event(MODE_WRITE, 8'hFF);
        send_event(MODE_WRITE, 8'h00);
        send_event(MODE_WRITE, 8'h00);
        send_event(MODE_WRITE, 8'hA5);
        send_event(MODE_WRITE, 8'h5A);
        send_event(MODE_WRITE, 8'h03);
        send_event(MODE_WRITE, 8'hF0);
        send_event(MODE_STOP, 8'h55);
        send_event(MODE_WRITE, 8'h4F);
        send_event(MODE_WRITE, 8'h50);
        send_event(MODE_ADDR, 8'h00);
        send_event(MODE_WRITE, 8'h5A);
        send_event(MODE_WRITE, 8'hFC);
        // read in the middle of a colour pair drops the list
        repeat (7) send_event(MODE_READ, 8'hAA);
        send_event(MODE_WRITE, 8'hFC);
        send_event(MODE_WRITE, 8'h51);
        send_event(MODE_STOP, 8'h00);

        drain_replies();

        while (events_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                send_event(MODE_ADDR, 8'($urandom));
                repeat ($urandom_range(1, 3)) begin
                    mask  = ($urandom_range(0, 15) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
                    pairs = $countones(mask);
                    send_event(MODE_WRITE, {CMD_SET_LEDS, mask});
                    // now and then a list is cut short
                    if (pairs != 0 && $urandom_range(0, 7) == 0) begin
                        send_colours($urandom_range(0, pairs - 1));
                        send_event(MODE_WRITE, 8'($urandom));
                    end else begin
                        send_colours(pairs);
                    end
                end
                repeat ($urandom_range(0, 8)) send_event(MODE_READ, 8'($urandom));
                if ($urandom_range(0, 5) != 0) send_event(MODE_STOP, 8'($urandom));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    mode = mode_t'($urandom_range(0, 3));
                    send_event(mode, 8'($urandom));
                end
            end
        end

        drain_replies();
        repeat (8) @(posedge aclk);
        if (replies.errors == 0 && replies.awaited_replies.size() == 0) begin
            $display("i2c_led_command_parser verification clean");
        end else begin
            $display("i2c_led_command_parser verification failed");
        end
        $finish;
    end

endmodule

@@ i2c_led_command_parser.f @@
rtl/core/ilcp_pkg.sv
rtl/core/ilcp_parser.sv
rtl/core/i2c_led_command_parser.sv
rtl/core/ilcp_checker.sv
verif/tb_i2c_led_command_parser.sv
